[rtl/sscab_pkg.sv]
`timescale 1ns / 1ps

package sscab_pkg;

   // Default depth of the column sum line store.
   localparam int MAX_WIDTH_DEF = 1024;

   localparam int COL_W   = 11;   // column counter, also the width_px register
   localparam int ROW_W   = 12;   // row counter
   localparam int HGT_W   = 13;   // height_px register
   localparam int SUM_W   = 12;   // one column sum of 16 samples
   localparam int ADD_W   = 10;   // four samples of one transaction
   localparam int CSR_W   = 13;   // widest configuration register
   localparam int CSR_A_W = 3;

   localparam logic [HGT_W-1:0] MAX_HEIGHT = 13'd4096;
   localparam logic [1:0]       SUBROW_LAST = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_A_W-1:0] CSR_SRC_RED   = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_SRC_GREEN = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_SRC_BLUE  = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_SRC_ALPHA = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_WIDTH_PX  = 3'd4;
   localparam logic [CSR_A_W-1:0] CSR_HEIGHT_PX = 3'd5;

   // Blue sits in the low byte, alpha in the high byte.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      logic first_sub;
      logic last_sub;
      logic row_end;
      logic frame_end;
   } item_ctrl_type;

   // Exact x / 255 for any x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

endpackage

[rtl/sscab_sums.sv]
`timescale 1ns / 1ps

module sscab_sums #(
   parameter int MAX_WIDTH = sscab_pkg::MAX_WIDTH_DEF,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       acc,
   input  logic [AW-1:0]              col,
   input  logic [31:0]                samples,
   input  sscab_pkg::pix_type         dst,
   input  sscab_pkg::item_ctrl_type   ctrl,
   output logic                       cov_valid,
   output logic [7:0]                 cov,
   output sscab_pkg::pix_type         cov_dst,
   output sscab_pkg::item_ctrl_type   cov_ctrl
);

   logic [sscab_pkg::SUM_W-1:0] sums_mem [MAX_WIDTH];

   logic                           s1_valid_ff;
   logic [AW-1:0]                  s1_col_ff;
   logic [sscab_pkg::ADD_W-1:0]    s1_add_ff;
   sscab_pkg::pix_type             s1_dst_ff;
   sscab_pkg::item_ctrl_type       s1_ctrl_ff;
   logic [sscab_pkg::SUM_W-1:0]    rdata_ff;
   logic                           fwd_hit_ff;
   logic [sscab_pkg::SUM_W-1:0]    fwd_data_ff;

   logic [sscab_pkg::ADD_W-1:0]    add;
   logic [sscab_pkg::SUM_W-1:0]    prev_sum;
   logic [sscab_pkg::SUM_W-1:0]    s1_sum;

   assign add = 10'(samples[7:0]) + 10'(samples[15:8])
              + 10'(samples[23:16]) + 10'(samples[31:24]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
         // The write of the item now in the second stage lands at this same edge,
         // so a read of that column must take the new sum from here instead.
         fwd_hit_ff  <= acc && s1_valid_ff && (col == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff   <= col;
         s1_add_ff   <= add;
         s1_dst_ff   <= dst;
         s1_ctrl_ff  <= ctrl;
         fwd_data_ff <= s1_sum;
      end
   end

   // Line store: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= sums_mem[col];
         if (s1_valid_ff) begin
            sums_mem[s1_col_ff] <= s1_sum;
         end
      end
   end

   assign prev_sum = fwd_hit_ff ? fwd_data_ff : rdata_ff;
   assign s1_sum   = s1_ctrl_ff.first_sub ? 12'(s1_add_ff) : prev_sum + 12'(s1_add_ff);

   assign cov_valid = s1_valid_ff && s1_ctrl_ff.last_sub;
   assign cov       = s1_sum[11:4];
   assign cov_dst   = s1_dst_ff;
   assign cov_ctrl  = s1_ctrl_ff;

endmodule

[rtl/sscab_blend.sv]
`timescale 1ns / 1ps

module sscab_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [7:0]                 cov,
   input  sscab_pkg::pix_type         dst,
   input  sscab_pkg::item_ctrl_type   ctrl,
   input  logic [7:0]                 src_red,
   input  logic [7:0]                 src_green,
   input  logic [7:0]                 src_blue,
   input  logic [7:0]                 src_alpha,
   output logic                       out_valid,
   output sscab_pkg::pix_type         out_pix,
   output logic                       out_row_end,
   output logic                       out_frame_end
);

   // Stage 2: coverage times layer alpha.
   logic                      s2_valid_ff;
   logic [15:0]               s2_prod_ff;
   sscab_pkg::pix_type        s2_dst_ff;
   sscab_pkg::item_ctrl_type  s2_ctrl_ff;

   // Stage 3: effective alpha.
   logic                      s3_valid_ff;
   logic [7:0]                s3_sa_ff;
   sscab_pkg::pix_type        s3_dst_ff;
   sscab_pkg::item_ctrl_type  s3_ctrl_ff;

   // Stage 4: the source and destination products of each channel.
   logic                      s4_valid_ff;
   logic [7:0]                s4_sa_ff;
   sscab_pkg::pix_type        s4_dst_ff;
   sscab_pkg::item_ctrl_type  s4_ctrl_ff;
   logic [15:0]               s4_sr_ff, s4_sg_ff, s4_sb_ff;
   logic [15:0]               s4_dr_ff, s4_dg_ff, s4_db_ff, s4_da_ff;

   logic [7:0]                inv_sa;
   logic [8:0]                sum_r, sum_g, sum_b, sum_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign inv_sa = 8'd255 - s3_sa_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= 16'(cov) * 16'(src_alpha);
         s2_dst_ff  <= dst;
         s2_ctrl_ff <= ctrl;

         s3_sa_ff   <= sscab_pkg::div255(s2_prod_ff);
         s3_dst_ff  <= s2_dst_ff;
         s3_ctrl_ff <= s2_ctrl_ff;

         s4_sa_ff   <= s3_sa_ff;
         s4_dst_ff  <= s3_dst_ff;
         s4_ctrl_ff <= s3_ctrl_ff;
         s4_sr_ff   <= 16'(src_red) * 16'(s3_sa_ff);
         s4_sg_ff   <= 16'(src_green) * 16'(s3_sa_ff);
         s4_sb_ff   <= 16'(src_blue) * 16'(s3_sa_ff);
         s4_dr_ff   <= 16'(s3_dst_ff.red) * 16'(inv_sa);
         s4_dg_ff   <= 16'(s3_dst_ff.green) * 16'(inv_sa);
         s4_db_ff   <= 16'(s3_dst_ff.blue) * 16'(inv_sa);
         s4_da_ff   <= 16'(s3_dst_ff.alpha) * 16'(inv_sa);
      end
   end

   // Each term is truncated on its own before the two are added.
   assign sum_r = 9'(sscab_pkg::div255(s4_sr_ff)) + 9'(sscab_pkg::div255(s4_dr_ff));
   assign sum_g = 9'(sscab_pkg::div255(s4_sg_ff)) + 9'(sscab_pkg::div255(s4_dg_ff));
   assign sum_b = 9'(sscab_pkg::div255(s4_sb_ff)) + 9'(sscab_pkg::div255(s4_db_ff));
   assign sum_a = 9'(s4_sa_ff) + 9'(sscab_pkg::div255(s4_da_ff));

   // A zero effective alpha also covers zero coverage: the destination passes.
   always_comb begin
      if (s4_sa_ff == 8'd0) begin
         out_pix = s4_dst_ff;
      end else begin
         out_pix.red   = sum_r[7:0];
         out_pix.green = sum_g[7:0];
         out_pix.blue  = sum_b[7:0];
         out_pix.alpha = sum_a[7:0];
      end
   end

   assign out_valid     = s4_valid_ff;
   assign out_row_end   = s4_ctrl_ff.row_end;
   assign out_frame_end = s4_ctrl_ff.frame_end;

endmodule

[rtl/supersample_coverage_alpha_blend.sv]
`timescale 1ns / 1ps

// Box-filters a 4x4 supersampled coverage mask and blends the layer colour
// over a premultiplied destination stream.
// Input channel (req_): one transaction carries the four coverage samples of
// one output column in one sub-row, plus the destination pixel, which is used
// only on the fourth sub-row. Transactions come in raster order of sub-rows.
// Result channel (rsp_): one blended pixel per transaction of the fourth
// sub-row, none for the others; tlast marks the end of an output row, tuser
// the end of the frame.
// Configuration (csr_): colour, alpha and frame size, written while idle.
// Column sums live in a single-port-read, single-port-write line store with a
// registered read; a read that hits the column being written back is forwarded.
// Throughput is one transaction per clock while the result channel is not stalled.
// After its transaction is accepted, a result passes through these registered steps:
// accumulate and alpha multiply, alpha divide, channel multiply, output register.
// If the receiver stalls with a result waiting, the whole pipeline holds and
// req_tready is low until the result is taken.
// Reset clears the counters, pipeline valids and registers to their defaults;
// the line store is not cleared, as every row group starts by writing it.
module supersample_coverage_alpha_blend #(
   parameter int MAX_WIDTH = sscab_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample_0, sample_1, sample_2, sample_3, dst_blue, dst_green, dst_red, dst_alpha
   input  logic [63:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pix_blue, pix_green, pix_red, pix_alpha
   output logic [31:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   // frame_end
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [sscab_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [sscab_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [7:0]                    src_red_ff, src_green_ff, src_blue_ff, src_alpha_ff;
   logic [sscab_pkg::COL_W-1:0]   width_px_ff;
   logic [sscab_pkg::HGT_W-1:0]   height_px_ff;

   logic [sscab_pkg::COL_W-1:0]   column_count_ff, column_count_in;
   logic [1:0]                    subrow_count_ff, subrow_count_in;
   logic [sscab_pkg::ROW_W-1:0]   row_count_ff, row_count_in;

   logic                          rsp_tvalid_ff;
   sscab_pkg::pix_type            rsp_pix_ff;
   logic                          rsp_row_end_ff, rsp_frame_end_ff;

   logic                          adv, acc;
   logic [sscab_pkg::COL_W-1:0]   width_eff;
   logic [sscab_pkg::HGT_W-1:0]   height_eff;
   logic                          last_col, last_row;
   logic [AW-1:0]                 col;
   sscab_pkg::item_ctrl_type      ctrl;

   logic                          cov_valid;
   logic [7:0]                    cov;
   sscab_pkg::pix_type            cov_dst;
   sscab_pkg::item_ctrl_type      cov_ctrl;

   logic                          blend_valid;
   sscab_pkg::pix_type            blend_pix;
   logic                          blend_row_end, blend_frame_end;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign acc        = req_tvalid && adv;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_red_ff   <= 8'd0;
         src_green_ff <= 8'd0;
         src_blue_ff  <= 8'd0;
         src_alpha_ff <= 8'd255;
         width_px_ff  <= 11'd1;
         height_px_ff <= 13'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            sscab_pkg::CSR_SRC_RED:   src_red_ff   <= csr_wdata[7:0];
            sscab_pkg::CSR_SRC_GREEN: src_green_ff <= csr_wdata[7:0];
            sscab_pkg::CSR_SRC_BLUE:  src_blue_ff  <= csr_wdata[7:0];
            sscab_pkg::CSR_SRC_ALPHA: src_alpha_ff <= csr_wdata[7:0];
            sscab_pkg::CSR_WIDTH_PX:  width_px_ff  <= csr_wdata[sscab_pkg::COL_W-1:0];
            sscab_pkg::CSR_HEIGHT_PX: height_px_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Out-of-range sizes are clamped; a counter left past the end by a size
   // change closes its row or frame on the next transaction.
   always_comb begin
      width_eff = (width_px_ff == '0) ? 11'd1 : width_px_ff;
      if (height_px_ff == '0) begin
         height_eff = 13'd1;
      end else if (height_px_ff > sscab_pkg::MAX_HEIGHT) begin
         height_eff = sscab_pkg::MAX_HEIGHT;
      end else begin
         height_eff = height_px_ff;
      end
      last_col = (column_count_ff >= width_eff - 11'd1)
              || (32'(column_count_ff) >= MAX_WIDTH - 1);
      last_row = ({1'b0, row_count_ff} >= height_eff - 13'd1);
      col = (32'(column_count_ff) < MAX_WIDTH) ? AW'(column_count_ff) : '0;

      ctrl.first_sub = (subrow_count_ff == 2'd0);
      ctrl.last_sub  = (subrow_count_ff == sscab_pkg::SUBROW_LAST);
      ctrl.row_end   = last_col;
      ctrl.frame_end = last_col && last_row;

      column_count_in = column_count_ff;
      subrow_count_in = subrow_count_ff;
      row_count_in    = row_count_ff;
      if (acc) begin
         if (last_col) begin
            column_count_in = '0;
            if (subrow_count_ff == sscab_pkg::SUBROW_LAST) begin
               subrow_count_in = 2'd0;
               row_count_in    = last_row ? '0 : row_count_ff + 12'd1;
            end else begin
               subrow_count_in = subrow_count_ff + 2'd1;
            end
         end else begin
            column_count_in = column_count_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         subrow_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         subrow_count_ff <= subrow_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   sscab_sums #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_sums (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .acc       (acc),
      .col       (col),
      .samples   (req_tdata[31:0]),
      .dst       (req_tdata[63:32]),
      .ctrl      (ctrl),
      .cov_valid (cov_valid),
      .cov       (cov),
      .cov_dst   (cov_dst),
      .cov_ctrl  (cov_ctrl)
   );

   sscab_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (cov_valid),
      .cov           (cov),
      .dst           (cov_dst),
      .ctrl          (cov_ctrl),
      .src_red       (src_red_ff),
      .src_green     (src_green_ff),
      .src_blue      (src_blue_ff),
      .src_alpha     (src_alpha_ff),
      .out_valid     (blend_valid),
      .out_pix       (blend_pix),
      .out_row_end   (blend_row_end),
      .out_frame_end (blend_frame_end)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= blend_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pix_ff       <= blend_pix;
         rsp_row_end_ff   <= blend_row_end;
         rsp_frame_end_ff <= blend_frame_end;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

endmodule

[rtl/sscab_checker.sv]
`timescale 1ns / 1ps

module sscab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A result held by the receiver must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A stalled result blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // The end of a frame is always the end of a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind supersample_coverage_alpha_blend sscab_checker u_sscab_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
